>>> src/ssps_pkg.sv
// ----------------------------------------------------------------------------
// ssps_pkg: shared types and constants for the segmented suffix product scan
// Holds the field widths, the register map and the word types that pass
// between the scan core and its output buffer.
// ----------------------------------------------------------------------------
package ssps_pkg;

	// Payload widths
	localparam int VALUE_W = 32;

	// Configuration port
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;

	// Register indexes (taken from paddr[2])
	localparam logic REG_EXCLUSIVE_MODE = 1'b0;

	// One result word
	typedef struct packed {
		logic [VALUE_W-1:0] product;
		logic               last_out;
		logic               overflow;
	} result_t;

	// Output buffer status, used by the core for read credit
	typedef struct packed {
		logic [1:0] level;
		logic       pop;
	} buf_stat_t;

endpackage

>>> src/ssps_in_if.sv
// ----------------------------------------------------------------------------
// ssps_in_if: input channel of the segmented suffix product scan
// Carries one vector element per word with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface ssps_in_if;
	logic                        valid;
	logic                        ready;
	logic [ssps_pkg::VALUE_W-1:0] value;
	logic                        joins_previous;
	logic                        last;

	modport source (output valid, output value, output joins_previous, output last,
		input ready);
	modport sink (input valid, input value, input joins_previous, input last,
		output ready);
endinterface

>>> src/ssps_out_if.sv
// ----------------------------------------------------------------------------
// ssps_out_if: output channel of the segmented suffix product scan
// Carries one result word per handshake with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface ssps_out_if;
	logic                        valid;
	logic                        ready;
	logic [ssps_pkg::VALUE_W-1:0] product;
	logic                        last_out;
	logic                        overflow;

	modport source (output valid, output product, output last_out, output overflow,
		input ready);
	modport sink (input valid, input product, input last_out, input overflow,
		output ready);
endinterface

>>> src/ssps_out_buf.sv
// ----------------------------------------------------------------------------
// ssps_out_buf: two-entry output buffer
// Decouples the result memory read from the consumer. The core pushes only
// when it holds credit, so a push never meets a full buffer.
// ----------------------------------------------------------------------------
module ssps_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ssps_pkg::result_t   push_word,
	output ssps_pkg::buf_stat_t stat,
	ssps_out_if.source          out_ch
);

	logic [1:0]        level_q;
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	ssps_pkg::result_t entry_q [2];
	logic              pop;

	// Drive the channel from the head entry
	assign pop             = out_ch.valid && out_ch.ready;
	assign out_ch.valid    = (level_q != 2'd0);
	assign out_ch.product  = entry_q[rd_ptr_q].product;
	assign out_ch.last_out = entry_q[rd_ptr_q].last_out;
	assign out_ch.overflow = entry_q[rd_ptr_q].overflow;

	assign stat.level = level_q;
	assign stat.pop   = pop;

	// Advance pointers and level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q  <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			level_q <= 2'(level_q + {1'b0, push} - {1'b0, pop});
		end
	end

	// Hold payload
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_word;
		end
	end

endmodule

>>> src/segmented_suffix_product_scan_core.sv
// ----------------------------------------------------------------------------
// segmented_suffix_product_scan_core: segmented suffix product scan
// Stores a vector, then walks it backwards to form per-segment suffix
// products and emits them in original order.
// ----------------------------------------------------------------------------
// Loading writes each element straight into the value memory. When the word
// marked last arrives (or a word arrives while DEPTH elements are already
// held, which closes the run with overflow set and drops that word), the input
// stalls for the run: the backward walk reads one element per cycle from the
// value memory and does one 32-bit multiply per cycle; emission then reads the
// result memory at one word per cycle while the consumer keeps up, through a
// two-entry output buffer. Input is taken again as soon as the last result
// read is issued. No clearing pass is needed after reset.
module segmented_suffix_product_scan_core #(
	parameter int DEPTH = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ssps_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [ssps_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [ssps_pkg::CFG_DATA_W-1:0] prdata,
	output logic                            pready,
	ssps_in_if.sink                         in_ch,
	ssps_out_if.source                      out_ch
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam int W = ssps_pkg::VALUE_W;

	typedef enum logic [2:0] {
		ST_LOAD = 3'b001,
		ST_WALK = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t state_q, state_next;

	// Configuration
	logic excl_q;

	// Load side
	logic [CW-1:0] count_q;
	logic          accept;
	logic          is_full;
	logic          trig;
	logic [CW-1:0] run_len;

	// Backward walk
	logic [CW-1:0] walk_left_q;
	logic [AW-1:0] walk_addr_q;
	logic          walk_rd_s1;
	logic [AW-1:0] walk_addr_s1;
	logic [W-1:0]  value_rd_s1;
	logic          join_rd_s1;
	logic [W-1:0]  rp_q;
	logic [W-1:0]  prod;
	logic          walk_issue;
	logic          walk_done;

	// Emission
	logic [CW-1:0]       n_q;
	logic                ovf_q;
	logic [CW-1:0]       emit_left_q;
	logic [AW-1:0]       emit_addr_q;
	logic                emit_rd_s1;
	logic                emit_last_s1;
	logic                emit_ovf_s1;
	logic [W-1:0]        result_rd_s1;
	logic                emit_issue;
	logic [2:0]          lvl_next;
	logic                credit_ok;
	ssps_pkg::buf_stat_t buf_stat;
	ssps_pkg::result_t   push_word;

	// Memories
	logic [W:0]   vmem [DEPTH];
	logic [W-1:0] rmem [DEPTH];

	// ------------------------------------------------------------------
	// Configuration port
	// ------------------------------------------------------------------
	assign pready = 1'b1;

	always_comb begin
		prdata = '0;
		if (paddr[2] == ssps_pkg::REG_EXCLUSIVE_MODE) begin
			prdata[0] = excl_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			excl_q <= 1'b0;
		end else if (psel && penable && pwrite && pready
			&& paddr[2] == ssps_pkg::REG_EXCLUSIVE_MODE) begin
			excl_q <= pwdata[0];
		end
	end

	// ------------------------------------------------------------------
	// Control decode
	// ------------------------------------------------------------------
	assign in_ch.ready = (state_q == ST_LOAD);
	assign accept      = in_ch.valid && in_ch.ready;
	assign is_full     = (count_q == DEPTH_C);
	assign trig        = accept && (is_full || in_ch.last);
	assign run_len     = is_full ? DEPTH_C : CW'(count_q + CW'(1));

	assign walk_issue = (state_q == ST_WALK) && (walk_left_q != '0);
	assign walk_done  = (state_q == ST_WALK) && (walk_left_q == '0) && !walk_rd_s1;

	// Read credit: space must remain for a word arriving next cycle
	assign lvl_next   = 3'({1'b0, buf_stat.level} + {2'b0, emit_rd_s1}
		- {2'b0, buf_stat.pop});
	assign credit_ok  = (lvl_next <= 3'd1);
	assign emit_issue = (state_q == ST_EMIT) && (emit_left_q != '0) && credit_ok;

	assign prod = rp_q * value_rd_s1[W-1:0];

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (trig) begin
					state_next = ST_WALK;
				end
			end
			ST_WALK: begin
				if (walk_done) begin
					state_next = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (emit_issue && emit_left_q == CW'(1)) begin
					state_next = ST_LOAD;
				end
			end
			default: state_next = ST_LOAD;
		endcase
	end

	// ------------------------------------------------------------------
	// Control registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			count_q      <= '0;
			walk_left_q  <= '0;
			walk_addr_q  <= '0;
			walk_rd_s1   <= 1'b0;
			rp_q         <= W'(1);
			n_q          <= '0;
			ovf_q        <= 1'b0;
			emit_left_q  <= '0;
			emit_addr_q  <= '0;
			emit_rd_s1   <= 1'b0;
			emit_last_s1 <= 1'b0;
			emit_ovf_s1  <= 1'b0;
		end else begin
			state_q    <= state_next;
			walk_rd_s1 <= walk_issue;
			emit_rd_s1 <= emit_issue;

			// Count stored elements; close the run on last or overflow
			if (trig) begin
				count_q     <= '0;
				n_q         <= run_len;
				ovf_q       <= is_full;
				walk_left_q <= run_len;
				walk_addr_q <= AW'(run_len - CW'(1));
				rp_q        <= W'(1);
			end else if (accept) begin
				count_q <= CW'(count_q + CW'(1));
			end

			// Step the read address down through the stored vector
			if (walk_issue) begin
				walk_left_q <= CW'(walk_left_q - CW'(1));
				walk_addr_q <= AW'(walk_addr_q - AW'(1));
			end

			// Carry the product across a segment, restart at a boundary
			if (walk_rd_s1) begin
				rp_q <= join_rd_s1 ? prod : W'(1);
			end

			// Arm emission once the walk has drained
			if (walk_done) begin
				emit_left_q <= n_q;
				emit_addr_q <= '0;
			end

			if (emit_issue) begin
				emit_left_q  <= CW'(emit_left_q - CW'(1));
				emit_addr_q  <= AW'(emit_addr_q + AW'(1));
				emit_last_s1 <= (emit_left_q == CW'(1));
				emit_ovf_s1  <= ovf_q;
			end
		end
	end

	// ------------------------------------------------------------------
	// Value/join memory: write on load, read during the walk
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept && !is_full) begin
			vmem[count_q[AW-1:0]] <= {in_ch.joins_previous, in_ch.value};
		end
		if (walk_issue) begin
			{join_rd_s1, value_rd_s1} <= vmem[walk_addr_q];
			walk_addr_s1              <= walk_addr_q;
		end
	end

	// ------------------------------------------------------------------
	// Result memory: write during the walk, read during emission
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (walk_rd_s1) begin
			rmem[walk_addr_s1] <= excl_q ? rp_q : prod;
		end
		if (emit_issue) begin
			result_rd_s1 <= rmem[emit_addr_q];
		end
	end

	// ------------------------------------------------------------------
	// Output buffer
	// ------------------------------------------------------------------
	assign push_word.product  = result_rd_s1;
	assign push_word.last_out = emit_last_s1;
	assign push_word.overflow = emit_ovf_s1;

	ssps_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (emit_rd_s1),
		.push_word (push_word),
		.stat      (buf_stat),
		.out_ch    (out_ch)
	);

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("stored element count exceeds depth");

	a_no_buf_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		emit_rd_s1 |-> (buf_stat.level != 2'd2) || buf_stat.pop)
		else $error("result word pushed into a full output buffer");

	a_walk_starts_at_one: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_WALK) |-> rp_q == W'(1))
		else $error("running product not restarted at walk start");

	a_walk_read_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		walk_rd_s1 |-> state_q == ST_WALK)
		else $error("walk read data returned outside the walk");

	a_emit_after_walk: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_EMIT) |-> $past(state_q == ST_WALK) && !walk_rd_s1)
		else $error("emission began with walk work outstanding");

endmodule

>>> bench/ssps_product_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ssps_product_checker: result checker for the segmented suffix product scan
// Watches the element and result channels and the mode register writes,
// keeps its own copy of the stored vector, forms the expected suffix
// products whenever a run closes and compares every result word in order.
// ----------------------------------------------------------------------------
module ssps_product_checker #(
	parameter int DEPTH = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic                            pready,
	input  logic [ssps_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [ssps_pkg::CFG_DATA_W-1:0] pwdata,
	ssps_in_if                              in_ch,
	ssps_out_if                             out_ch,
	output int                              mismatches,
	output int                              pending,
	output int                              checked
);

	// Shadow of the stored vector and of the mode register
	logic [ssps_pkg::VALUE_W-1:0] held_value [DEPTH];
	logic                         held_joins [DEPTH];
	int                           held_count = 0;
	logic                         exclusive = 1'b0;

	// Expected result words, oldest first
	ssps_pkg::result_t            product_q[$];
	int                           miss = 0;
	int                           seen = 0;

	// Walk the held vector backwards and queue one result word per element
	task automatic close_run(input logic truncated);
		logic [ssps_pkg::VALUE_W-1:0] carry;
		logic [ssps_pkg::VALUE_W-1:0] suffix [DEPTH];
		ssps_pkg::result_t            word;
		int                           k;
		carry = 1;
		for (k = held_count - 1; k >= 0; k--) begin
			suffix[k] = exclusive ? carry : carry * held_value[k];
			// a segment boundary restarts the product
			carry = held_joins[k] ? carry * held_value[k] : 1;
		end
		for (k = 0; k < held_count; k++) begin
			word.product  = suffix[k];
			word.last_out = (k == held_count - 1);
			word.overflow = truncated;
			product_q = {product_q, word};
		end
		held_count = 0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		ssps_pkg::result_t got;
		ssps_pkg::result_t want;
		if (!arst_n) begin
			held_count = 0;
			exclusive  = 1'b0;
			product_q.delete();
			miss = 0;
			seen = 0;
			mismatches <= 0;
			pending    <= 0;
			checked    <= 0;
		end else begin
			// track the mode register, other indexes are ignored
			if (psel && penable && pwrite && pready
					&& paddr[2] == ssps_pkg::REG_EXCLUSIVE_MODE)
				exclusive = pwdata[0];

			// compare each result word with the oldest expectation
			if (out_ch.valid && out_ch.ready) begin
				got.product  = out_ch.product;
				got.last_out = out_ch.last_out;
				got.overflow = out_ch.overflow;
				seen++;
				if (product_q.size() == 0) begin
					if (miss < 10)
						$display({"tb: result word %0d with none expected: ",
							"product=%0d last_out=%b overflow=%b"},
							seen, $signed(got.product), got.last_out, got.overflow);
					miss++;
				end else begin
					want = product_q.pop_front();
					if (got.product !== want.product || got.last_out !== want.last_out ||
							got.overflow !== want.overflow) begin
						if (miss < 10) begin
							$display("tb: result word %0d mismatch", seen);
							$display("    expected product=%0d last_out=%b overflow=%b",
								$signed(want.product), want.last_out, want.overflow);
							$display("    actual   product=%0d last_out=%b overflow=%b",
								$signed(got.product), got.last_out, got.overflow);
						end
						miss++;
					end
				end
			end

			// store each element word, close the run on last or when full
			if (in_ch.valid && in_ch.ready) begin
				if (held_count >= DEPTH) begin
					close_run(1'b1);
				end else begin
					held_value[held_count] = in_ch.value;
					held_joins[held_count] = in_ch.joins_previous;
					held_count++;
					if (in_ch.last)
						close_run(1'b0);
				end
			end

			mismatches <= miss;
			pending    <= product_q.size();
			checked    <= seen;
		end
	end

endmodule

>>> bench/tb_segmented_suffix_product_scan_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_segmented_suffix_product_scan_core: testbench for the scan core
// Drives element words and mode register writes, stalls the result side at
// random and leaves all prediction and comparison to the product checker.
// Covers both product modes, segment edges, value extremes and truncated runs.
// ----------------------------------------------------------------------------
module tb_segmented_suffix_product_scan_core;

	localparam int DEPTH        = 64;
	localparam int IDLE_PCT     = 33;
	localparam int DRAIN_CYCLES = 16;
	localparam int STALL_LIMIT  = 5000;

	localparam logic UNUSED_REG     = 1'b1;
	localparam logic MODE_INCLUSIVE = 1'b0;
	localparam logic MODE_EXCLUSIVE = 1'b1;

	localparam logic [ssps_pkg::VALUE_W-1:0] INT_MIN_V = 32'h8000_0000;
	localparam logic [ssps_pkg::VALUE_W-1:0] INT_MAX_V = 32'h7FFF_FFFF;
	localparam logic [ssps_pkg::VALUE_W-1:0] MINUS_ONE = 32'hFFFF_FFFF;

	logic                            clk;
	logic                            arst_n;
	logic                            psel;
	logic                            penable;
	logic                            pwrite;
	logic [ssps_pkg::CFG_ADDR_W-1:0] paddr;
	logic [ssps_pkg::CFG_DATA_W-1:0] pwdata;
	logic [ssps_pkg::CFG_DATA_W-1:0] prdata;
	logic                            pready;

	logic calm;
	int   mismatches;
	int   pending;
	int   checked;
	int   elements_sent = 0;
	int   runs_sent = 0;
	int   truncated_runs = 0;
	int   quiet_cycles = 0;

	ssps_in_if  in_if ();
	ssps_out_if out_if ();

	segmented_suffix_product_scan_core #(
		.DEPTH (DEPTH)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.in_ch   (in_if),
		.out_ch  (out_if)
	);

	ssps_product_checker #(
		.DEPTH (DEPTH)
	) product_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.in_ch      (in_if),
		.out_ch     (out_if),
		.mismatches (mismatches),
		.pending    (pending),
		.checked    (checked)
	);

	always #10 clk = ~clk;

	// Stall the result side at random unless in a calm stretch
	always @(posedge clk) begin
		out_if.ready <= arst_n && (calm || $urandom_range(99) >= IDLE_PCT);
	end

	// End the run when no word moves for too long
	always @(posedge clk) begin
		if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles < STALL_LIMIT) begin
			quiet_cycles <= quiet_cycles + 1;
		end else begin
			$display("tb: no word moved for %0d cycles", STALL_LIMIT);
			$display("tb: failure");
			$finish;
		end
	end

	// Register write: setup, then access
	task automatic write_reg(input logic [ssps_pkg::CFG_ADDR_W-1:0] addr,
		input logic [ssps_pkg::CFG_DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Offer one element word, with random gaps ahead of it
	task automatic send_word(input logic [ssps_pkg::VALUE_W-1:0] v, input logic joins,
		input logic closes);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_if.valid <= 1'b0;
			@(posedge clk);
		end
		in_if.valid          <= 1'b1;
		in_if.value          <= v;
		in_if.joins_previous <= joins;
		in_if.last           <= closes;
		@(posedge clk);
		while (in_if.ready !== 1'b1) @(posedge clk);
		elements_sent++;
	endtask

	// Mostly small factors so products survive long segments, plus extremes
	function automatic logic [ssps_pkg::VALUE_W-1:0] random_value();
		logic [ssps_pkg::VALUE_W-1:0] v;
		case ($urandom_range(3))
			0, 1: v = $urandom_range(8) - 4;
			2: v = $urandom();
			default: begin
				case ($urandom_range(4))
					0: v = INT_MIN_V;
					1: v = INT_MAX_V;
					2: v = MINUS_ONE;
					3: v = 1;
					default: v = 0;
				endcase
			end
		endcase
		return v;
	endfunction

	task automatic send_run(input int len, input logic closes);
		int k;
		for (k = 0; k < len; k++)
			send_word(random_value(), $urandom_range(9) < 7, closes && k == len - 1);
		runs_sent++;
	endtask

	// Fill the store, then one extra word that is dropped and closes the run
	task automatic overflow_run();
		send_run(DEPTH, 1'b0);
		send_word(random_value(), 1'($urandom_range(1)), 1'($urandom_range(1)));
		truncated_runs++;
	endtask

	// Hold input until every expected result has come, plus a margin
	task automatic drain_results();
		in_if.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_mode(input logic mode);
		drain_results();
		write_reg({ssps_pkg::REG_EXCLUSIVE_MODE, 2'b00},
			{{(ssps_pkg::CFG_DATA_W-1){1'b0}}, mode});
	endtask

	task automatic random_phase(input int budget);
		int stop;
		int pick;
		stop = elements_sent + budget;
		while (elements_sent < stop) begin
			pick = $urandom_range(99);
			if (pick < 60)
				send_run($urandom_range(6, 1), 1'b1);
			else if (pick < 85)
				send_run($urandom_range(24, 7), 1'b1);
			else if (pick < 96)
				send_run($urandom_range(DEPTH, 25), 1'b1);
			else
				overflow_run();
		end
	endtask

	// Mixed segments with sign and wrap extremes
	task automatic mixed_run();
		send_word(INT_MIN_V, 1'b1, 1'b0);
		send_word(MINUS_ONE, 1'b1, 1'b0);
		send_word(INT_MAX_V, 1'b1, 1'b0);
		send_word(32'd3, 1'b0, 1'b0);
		send_word(32'd0, 1'b1, 1'b0);
		send_word(-32'sd2, 1'b1, 1'b0);
		send_word(32'd5, 1'b0, 1'b1);
		runs_sent++;
	endtask

	initial begin
		clk                  = 1'b0;
		arst_n               = 1'b0;
		psel                 = 1'b0;
		penable              = 1'b0;
		pwrite               = 1'b0;
		paddr                = '0;
		pwdata               = '0;
		in_if.valid          = 1'b0;
		in_if.value          = '0;
		in_if.joins_previous = 1'b0;
		in_if.last           = 1'b0;
		out_if.ready         = 1'b0;
		calm                 = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// inclusive mode: single element, mixed segments, all separate
		set_mode(MODE_INCLUSIVE);
		write_reg({UNUSED_REG, 2'b00}, '1);
		send_word(INT_MAX_V, 1'b0, 1'b1);
		runs_sent++;
		mixed_run();
		send_word(32'd2, 1'b0, 1'b0);
		send_word(-32'sd3, 1'b0, 1'b0);
		send_word(32'd1, 1'b0, 1'b1);
		runs_sent++;

		// exclusive mode: single element, same mixed run, wrapping product
		set_mode(MODE_EXCLUSIVE);
		send_word(-32'sd7, 1'b1, 1'b1);
		runs_sent++;
		mixed_run();
		send_word(32'h0000_FFFF, 1'b1, 1'b0);
		send_word(32'h0001_0001, 1'b1, 1'b0);
		send_word(MINUS_ONE, 1'b1, 1'b1);
		runs_sent++;

		// random runs, inclusive, starting with a truncated run
		set_mode(MODE_INCLUSIVE);
		overflow_run();
		drain_results();
		random_phase(45);

		// random runs, exclusive, the first part without any idling
		set_mode(MODE_EXCLUSIVE);
		calm = 1'b1;
		random_phase(35);
		calm = 1'b0;
		random_phase(30);

		// random runs, inclusive, starting with a run that exactly fills the store
		set_mode(MODE_INCLUSIVE);
		send_run(DEPTH, 1'b1);
		random_phase(35);

		drain_results();
		$display("tb: %0d elements in %0d runs, %0d of them cut off at capacity",
			elements_sent, runs_sent, truncated_runs);
		$display("tb: %0d result words checked over both product modes, %0d mismatches",
			checked, mismatches);
		if (mismatches == 0 && pending == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

>>> sim.f
src/ssps_pkg.sv
src/ssps_in_if.sv
src/ssps_out_if.sv
src/ssps_out_buf.sv
src/segmented_suffix_product_scan_core.sv
bench/ssps_product_checker.sv
bench/tb_segmented_suffix_product_scan_core.sv
